// ----- rtl/tcw_pkg.sv -----
// tcw_pkg: screen geometry, command and character codes, op and result types
// for the text console cell writer. Depends on nothing; the interfaces and the ram do not import it.
`default_nettype none

package tcw_pkg;

    localparam int COLUMNS     = 80;
    localparam int ROWS        = 25;
    localparam int CELLS       = ROWS * COLUMNS;
    localparam int ADDR_W      = $clog2(CELLS);
    localparam int ROW_W       = 5;
    localparam int COL_W       = 7;
    localparam int CMD_W       = 3;
    localparam int CHAR_W      = 8;
    localparam int ATTR_W      = 8;
    localparam int CELL_W      = 16;
    localparam int POS_W       = 11;
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    localparam logic [ADDR_W-1:0] CELL_LAST  = ADDR_W'(CELLS - 1);
    localparam logic [ADDR_W-1:0] SCROLL_END = ADDR_W'(CELLS - COLUMNS);
    localparam logic [ADDR_W-1:0] BOTTOM_POS = ADDR_W'((ROWS - 1) * COLUMNS);

    localparam logic [CMD_W-1:0] CMD_PUT    = 3'd0;
    localparam logic [CMD_W-1:0] CMD_SET    = 3'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_READ   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_PUT_AT = 3'd4;

    localparam logic [CHAR_W-1:0] CH_NL    = 8'h0a;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0d;
    localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [7:0]        TAB_MASK = 8'hf8;

    localparam logic [ATTR_W-1:0] RESET_ATTR = 8'h07;
    localparam logic [CELL_W-1:0] RESET_CELL = {RESET_ATTR, CH_SPACE};

    typedef enum logic [3:0] {
        OP_PRINT,
        OP_NEWLINE,
        OP_RETURN,
        OP_BACKSPACE,
        OP_TAB,
        OP_SET,
        OP_CLEAR,
        OP_READ,
        OP_PUT_AT,
        OP_BAD,
        OP_NONE
    } t_op_kind;

    typedef struct packed {
        t_op_kind          kind;
        logic [CHAR_W-1:0] ch;
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
        logic [ADDR_W-1:0] addr;
    } t_op;

    typedef struct packed {
        logic [POS_W-1:0]  cursor_pos;
        logic [CELL_W-1:0] cell_data;
        logic              scrolled;
        logic              out_of_range;
    } t_res;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_READ,
        ST_SCROLL,
        ST_BLANK,
        ST_FILL,
        ST_DONE
    } t_state;

endpackage

`default_nettype wire

// ----- rtl/tcw_cmd_if.sv -----
// tcw_cmd_if: command channel, valid/ready plus the command fields
// depends on nothing
`default_nettype none

interface tcw_cmd_if;
    logic       valid;
    logic       ready;
    logic [2:0] cmd;
    logic [7:0] char_code;
    logic [4:0] row_index;
    logic [6:0] col_index;

    modport source (output valid, output cmd, output char_code, output row_index,
                    output col_index, input ready);
    modport sink (input valid, input cmd, input char_code, input row_index,
                  input col_index, output ready);
endinterface

`default_nettype wire

// ----- rtl/tcw_res_if.sv -----
// tcw_res_if: result channel, valid/ready plus the result fields
// depends on nothing
`default_nettype none

interface tcw_res_if;
    logic        valid;
    logic        ready;
    logic [10:0] cursor_pos;
    logic [15:0] cell_data;
    logic        scrolled;
    logic        out_of_range;

    modport source (output valid, output cursor_pos, output cell_data, output scrolled,
                    output out_of_range, input ready);
    modport sink (input valid, input cursor_pos, input cell_data, input scrolled,
                  input out_of_range, output ready);
endinterface

`default_nettype wire

// ----- rtl/tcw_ram.sv -----
// tcw_ram: generic single write port, single read port ram with registered read
// depends on nothing
`default_nettype none

module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ----- rtl/tcw_front.sv -----
// tcw_front: accepts command items, range checks and decodes them into ops
// depends on tcw_pkg and tcw_cmd_if
`default_nettype none

module tcw_front (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    tcw_cmd_if.sink    i_cmd,
    input  wire logic  i_hold,
    input  wire logic  i_q_full,
    output logic       o_push,
    output tcw_pkg::t_op o_op
);
    import tcw_pkg::*;

    logic r_valid;
    logic n_valid;
    t_op  r_op;
    t_op  n_op;
    logic bad;
    logic accept;

    assign i_cmd.ready = !i_hold && (!r_valid || !i_q_full);
    assign accept      = i_cmd.valid && i_cmd.ready;
    assign o_push      = r_valid && !i_q_full;
    assign o_op        = r_op;

    always_comb begin
        bad       = (int'(i_cmd.row_index) >= ROWS) || (int'(i_cmd.col_index) >= COLUMNS);
        n_op.ch   = i_cmd.char_code;
        n_op.row  = i_cmd.row_index;
        n_op.col  = i_cmd.col_index;
        n_op.addr = ADDR_W'(int'(i_cmd.row_index) * COLUMNS + int'(i_cmd.col_index));
        case (i_cmd.cmd)
            CMD_PUT: begin
                case (i_cmd.char_code)
                    CH_NL:   n_op.kind = OP_NEWLINE;
                    CH_CR:   n_op.kind = OP_RETURN;
                    CH_BS:   n_op.kind = OP_BACKSPACE;
                    CH_TAB:  n_op.kind = OP_TAB;
                    default: n_op.kind = OP_PRINT;
                endcase
            end
            CMD_SET:    n_op.kind = bad ? OP_BAD : OP_SET;
            CMD_CLEAR:  n_op.kind = OP_CLEAR;
            CMD_READ:   n_op.kind = bad ? OP_BAD : OP_READ;
            CMD_PUT_AT: n_op.kind = bad ? OP_BAD : OP_PUT_AT;
            default:    n_op.kind = OP_NONE;
        endcase
    end

    assign n_valid = accept || (r_valid && i_q_full);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        if (accept) begin
            r_op <= n_op;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/tcw_fifo.sv -----
// tcw_fifo: short op queue between the decode front and the execute back
// depends on tcw_pkg
`default_nettype none

module tcw_fifo (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_push,
    input  wire tcw_pkg::t_op i_op,
    output logic              o_full,
    input  wire logic         i_pop,
    output logic              o_empty,
    output tcw_pkg::t_op      o_op
);
    import tcw_pkg::*;

    t_op                 r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr_ptr;
    logic [QUEUE_AW-1:0] r_rd_ptr;
    logic [QUEUE_CW-1:0] r_count;
    logic                do_push;
    logic                do_pop;

    assign o_full  = (r_count == QUEUE_CW'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_op    = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_op;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/tcw_back.sv -----
// tcw_back: executes ops against the screen ram and cursor, sweeps for scroll and
// clear, holds the result register. depends on tcw_pkg, tcw_res_if, tcw_ram
`default_nettype none

module tcw_back (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic [tcw_pkg::ATTR_W-1:0] i_attr,
    input  wire logic                  i_op_valid,
    input  wire tcw_pkg::t_op          i_op,
    output logic                       o_pop,
    output logic                       o_init_busy,
    tcw_res_if.source                  o_res
);
    import tcw_pkg::*;

    t_state            r_state;
    t_state            n_state;
    logic [ADDR_W-1:0] r_cnt;
    logic [ADDR_W-1:0] n_cnt;
    logic [ROW_W-1:0]  r_row;
    logic [ROW_W-1:0]  n_row;
    logic [COL_W-1:0]  r_col;
    logic [COL_W-1:0]  n_col;
    logic [ADDR_W-1:0] r_pos;
    logic [ADDR_W-1:0] n_pos;
    logic [CELL_W-1:0] r_data;
    logic [CELL_W-1:0] n_data;
    logic              r_scr;
    logic              n_scr;
    logic              r_oor;
    logic              n_oor;
    logic              r_out_valid;
    logic              n_out_valid;
    t_res              r_out;
    t_res              n_out;

    // single op step
    logic [ROW_W-1:0]  s_row;
    logic [COL_W-1:0]  s_col;
    logic [ADDR_W-1:0] s_pos;
    logic              s_scroll;
    logic              s_we;
    logic [ADDR_W-1:0] s_waddr;
    logic [CELL_W-1:0] s_wdata;
    logic              s_oor;
    logic              do_nl;
    logic [7:0]        tab_col;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [CELL_W-1:0] ram_wdata;
    logic [ADDR_W-1:0] ram_raddr;
    logic [CELL_W-1:0] ram_rdata;
    logic [CELL_W-1:0] blank_cell;
    logic              out_free;

    assign blank_cell  = {i_attr, CH_SPACE};
    assign out_free    = !r_out_valid || o_res.ready;
    assign o_init_busy = (r_state == ST_INIT);

    assign o_res.valid        = r_out_valid;
    assign o_res.cursor_pos   = r_out.cursor_pos;
    assign o_res.cell_data    = r_out.cell_data;
    assign o_res.scrolled     = r_out.scrolled;
    assign o_res.out_of_range = r_out.out_of_range;

    tcw_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELLS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        tab_col  = ({1'b0, r_col} + 8'd8) & TAB_MASK;
        do_nl    = 1'b0;
        s_row    = r_row;
        s_col    = r_col;
        s_pos    = r_pos;
        s_scroll = 1'b0;
        s_we     = 1'b0;
        s_waddr  = r_pos;
        s_wdata  = {i_attr, i_op.ch};
        s_oor    = 1'b0;
        case (i_op.kind)
            OP_PRINT: begin
                s_we = 1'b1;
                if (r_col == COL_W'(COLUMNS - 1)) begin
                    do_nl = 1'b1;
                end else begin
                    s_col = r_col + 1'b1;
                    s_pos = r_pos + 1'b1;
                end
            end
            OP_NEWLINE: do_nl = 1'b1;
            OP_RETURN: begin
                s_col = '0;
                s_pos = r_pos - ADDR_W'(r_col);
            end
            OP_BACKSPACE: begin
                if (r_col != '0) begin
                    s_col   = r_col - 1'b1;
                    s_pos   = r_pos - 1'b1;
                    s_we    = 1'b1;
                    s_waddr = r_pos - 1'b1;
                    s_wdata = blank_cell;
                end
            end
            OP_TAB: begin
                if (int'(tab_col) >= COLUMNS) begin
                    do_nl = 1'b1;
                end else begin
                    s_col = COL_W'(tab_col);
                    s_pos = r_pos - ADDR_W'(r_col) + ADDR_W'(tab_col);
                end
            end
            OP_SET: begin
                s_row = i_op.row;
                s_col = i_op.col;
                s_pos = i_op.addr;
            end
            OP_CLEAR: begin
                s_row = '0;
                s_col = '0;
                s_pos = '0;
            end
            OP_PUT_AT: begin
                s_we    = 1'b1;
                s_waddr = i_op.addr;
            end
            OP_BAD: s_oor = 1'b1;
            default: ;
        endcase
        if (do_nl) begin
            s_col = '0;
            if (r_row == ROW_W'(ROWS - 1)) begin
                s_scroll = 1'b1;
                s_pos    = BOTTOM_POS;
            end else begin
                s_row = r_row + 1'b1;
                s_pos = r_pos - ADDR_W'(r_col) + ADDR_W'(COLUMNS);
            end
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_INIT: begin
                if (r_cnt == CELL_LAST) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_op_valid) begin
                    if (i_op.kind == OP_CLEAR) begin
                        n_state = ST_FILL;
                    end else if (i_op.kind == OP_READ) begin
                        n_state = ST_READ;
                    end else if (s_scroll) begin
                        n_state = ST_SCROLL;
                    end else begin
                        n_state = ST_DONE;
                    end
                end
            end
            ST_READ: n_state = ST_DONE;
            ST_SCROLL: begin
                if (r_cnt == SCROLL_END) begin
                    n_state = ST_BLANK;
                end
            end
            ST_BLANK, ST_FILL: begin
                if (r_cnt == CELL_LAST) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_cnt       = r_cnt;
        n_row       = r_row;
        n_col       = r_col;
        n_pos       = r_pos;
        n_data      = r_data;
        n_scr       = r_scr;
        n_oor       = r_oor;
        n_out       = r_out;
        n_out_valid = r_out_valid && !o_res.ready;
        o_pop       = 1'b0;
        ram_we      = 1'b0;
        ram_waddr   = r_cnt;
        ram_wdata   = blank_cell;
        ram_raddr   = r_cnt + ADDR_W'(COLUMNS);
        case (r_state)
            ST_INIT: begin
                ram_we    = 1'b1;
                ram_wdata = RESET_CELL;
                n_cnt     = (r_cnt == CELL_LAST) ? '0 : r_cnt + 1'b1;
            end
            ST_IDLE: begin
                if (i_op_valid) begin
                    o_pop     = 1'b1;
                    n_row     = s_row;
                    n_col     = s_col;
                    n_pos     = s_pos;
                    n_data    = '0;
                    n_scr     = s_scroll;
                    n_oor     = s_oor;
                    ram_we    = s_we;
                    ram_waddr = s_waddr;
                    ram_wdata = s_wdata;
                    ram_raddr = i_op.addr;
                    n_cnt     = '0;
                end
            end
            ST_READ: n_data = ram_rdata;
            ST_SCROLL: begin
                // read runs one cell ahead of the write into the row above
                if (r_cnt != '0) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_cnt - 1'b1;
                    ram_wdata = ram_rdata;
                end
                if (r_cnt != SCROLL_END) begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            ST_BLANK, ST_FILL: begin
                ram_we = 1'b1;
                n_cnt  = r_cnt + 1'b1;
            end
            ST_DONE: begin
                if (out_free) begin
                    n_out_valid        = 1'b1;
                    n_out.cursor_pos   = POS_W'(r_pos);
                    n_out.cell_data    = r_data;
                    n_out.scrolled     = r_scr;
                    n_out.out_of_range = r_oor;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_INIT;
            r_cnt       <= '0;
            r_row       <= '0;
            r_col       <= '0;
            r_pos       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_row       <= n_row;
            r_col       <= n_col;
            r_pos       <= n_pos;
            r_out_valid <= n_out_valid;
        end
        r_data <= n_data;
        r_scr  <= n_scr;
        r_oor  <= n_oor;
        r_out  <= n_out;
    end

endmodule

`default_nettype wire

// ----- rtl/text_console_cell_writer_top.sv -----
// Text console cell writer: an 80 by 25 screen of 16-bit cells (attribute high byte,
// character low byte) with a cursor, driven by command items; every item returns one
// result item with the cursor position. After reset the block first clears the screen
// to space on attribute 0x07, one cell per cycle, and takes no item meanwhile; the
// attribute register may be written at any time. A decode front and a two-entry op
// queue feed an execute back end built around a single screen memory with one write
// and one registered read port. A cell read passes through an extra read state.
// A clear writes every cell once, and a scroll copies each row up through the memory's
// one write port and blanks the bottom row. The attribute register applies to every
// character and blank cell written afterward, but not to the reset clear.
`default_nettype none

module text_console_cell_writer_top (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_cfg_wr_en,
    input  wire logic [tcw_pkg::ATTR_W-1:0] i_cfg_wr_data,
    tcw_cmd_if.sink                         i_cmd,
    tcw_res_if.source                       o_res
);
    import tcw_pkg::*;

    logic [ATTR_W-1:0] r_attr;
    logic              init_busy;
    logic              q_push;
    logic              q_full;
    logic              q_pop;
    logic              q_empty;
    t_op               front_op;
    t_op               back_op;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attr <= RESET_ATTR;
        end else if (i_cfg_wr_en) begin
            r_attr <= i_cfg_wr_data;
        end
    end

    tcw_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (i_cmd),
        .i_hold   (init_busy),
        .i_q_full (q_full),
        .o_push   (q_push),
        .o_op     (front_op)
    );

    tcw_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_op    (front_op),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_op    (back_op)
    );

    tcw_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_attr      (r_attr),
        .i_op_valid  (!q_empty),
        .i_op        (back_op),
        .o_pop       (q_pop),
        .o_init_busy (init_busy),
        .o_res       (o_res)
    );

endmodule

`default_nettype wire

// ----- rtl/tcw_checker.sv -----
// tcw_checker: port level checks on the result channel of the console writer
// depends on tcw_pkg; bound to text_console_cell_writer_top below
`default_nettype none

module tcw_checker (
    input wire logic                      i_clk,
    input wire logic                      i_rst_n,
    input wire logic                      i_valid,
    input wire logic                      i_ready,
    input wire logic [tcw_pkg::POS_W-1:0] i_cursor_pos,
    input wire logic [15:0]               i_cell_data,
    input wire logic                      i_scrolled,
    input wire logic                      i_out_of_range
);
    import tcw_pkg::*;

    // stalled item stays offered
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid)
        else $error("result item dropped while stalled");

    // a rejected position never returns cell data or scrolls
    a_oor_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_out_of_range |-> (i_cell_data == '0) && !i_scrolled)
        else $error("out of range item carries data or scroll");

    // scroll leaves the cursor at the start of the bottom row
    a_scroll_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_scrolled |-> i_cursor_pos == POS_W'((ROWS - 1) * COLUMNS))
        else $error("cursor not on bottom row after scroll");

    // cursor always lies on the screen
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> int'(i_cursor_pos) < CELLS)
        else $error("cursor position off screen");

endmodule

bind text_console_cell_writer_top tcw_checker u_tcw_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (o_res.valid),
    .i_ready        (o_res.ready),
    .i_cursor_pos   (o_res.cursor_pos),
    .i_cell_data    (o_res.cell_data),
    .i_scrolled     (o_res.scrolled),
    .i_out_of_range (o_res.out_of_range)
);

`default_nettype wire

// ----- tb/tb_text_console_cell_writer_top.sv -----
// tb_text_console_cell_writer_top: drives console commands with random gaps and stalls,
// predicts cursor, cell reads, scrolls and range flags from its own screen copy.
// Depends on tcw_pkg, tcw_cmd_if, tcw_res_if and text_console_cell_writer_top.
`timescale 1ns / 100ps

import tcw_pkg::*;

typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [CHAR_W-1:0] ch;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
} console_cmd_t;

class console_scoreboard;
    logic [CELL_W-1:0] cells [CELLS];
    int unsigned       cur_row;
    int unsigned       cur_col;
    logic [ATTR_W-1:0] attr;
    t_res              expected_q [$];
    int unsigned       error_count;
    int unsigned       checked_count;
    int unsigned       scroll_count;
    int unsigned       bad_pos_count;

    function new();
        attr = RESET_ATTR;
        cur_row = 0;
        cur_col = 0;
        error_count = 0;
        checked_count = 0;
        scroll_count = 0;
        bad_pos_count = 0;
        blank_screen();
    endfunction

    function void set_attribute(logic [ATTR_W-1:0] value);
        attr = value;
    endfunction

    function int unsigned pending();
        return expected_q.size();
    endfunction

    function void blank_screen();
        foreach (cells[i]) cells[i] = {attr, CH_SPACE};
    endfunction

    function bit roll_up();
        for (int i = 0; i < CELLS - COLUMNS; i++) cells[i] = cells[i + COLUMNS];
        for (int i = (ROWS - 1) * COLUMNS; i < CELLS; i++) cells[i] = {attr, CH_SPACE};
        cur_row = ROWS - 1;
        return 1'b1;
    endfunction

    function bit line_feed();
        cur_col = 0;
        cur_row++;
        if (cur_row >= ROWS) return roll_up();
        return 1'b0;
    endfunction

    function bit print_char(logic [CHAR_W-1:0] ch);
        case (ch)
            CH_NL: return line_feed();
            CH_CR: begin
                cur_col = 0;
                return 1'b0;
            end
            CH_BS: begin
                if (cur_col > 0) begin
                    cur_col--;
                    cells[cur_row * COLUMNS + cur_col] = {attr, CH_SPACE};
                end
                return 1'b0;
            end
            CH_TAB: begin
                cur_col = (cur_col + 8) & TAB_MASK;
                if (cur_col >= COLUMNS) return line_feed();
                return 1'b0;
            end
            default: begin
                cells[cur_row * COLUMNS + cur_col] = {attr, ch};
                cur_col++;
                if (cur_col >= COLUMNS) return line_feed();
                return 1'b0;
            end
        endcase
    endfunction

    function void note_command(console_cmd_t c);
        t_res r;
        bit   bad;
        bad = (c.row >= ROWS) || (c.col >= COLUMNS);
        r = '0;
        case (c.cmd)
            CMD_PUT: r.scrolled = print_char(c.ch);
            CMD_SET: begin
                if (bad) begin
                    r.out_of_range = 1'b1;
                end else begin
                    cur_row = c.row;
                    cur_col = c.col;
                end
            end
            CMD_CLEAR: begin
                blank_screen();
                cur_row = 0;
                cur_col = 0;
            end
            CMD_READ: begin
                if (bad) r.out_of_range = 1'b1;
                else r.cell_data = cells[c.row * COLUMNS + c.col];
            end
            CMD_PUT_AT: begin
                if (bad) r.out_of_range = 1'b1;
                else cells[c.row * COLUMNS + c.col] = {attr, c.ch};
            end
            default: ;
        endcase
        r.cursor_pos = POS_W'(cur_row * COLUMNS + cur_col);
        if (r.scrolled) scroll_count++;
        if (r.out_of_range) bad_pos_count++;
        expected_q.push_back(r);
    endfunction

    function void report(string field, logic [31:0] want, logic [31:0] got);
        $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
        error_count++;
    endfunction

    function void check_result(t_res got);
        t_res want;
        if (expected_q.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual pos 0x%0h data 0x%0h",
                     $time, got.cursor_pos, got.cell_data);
            error_count++;
            return;
        end
        want = expected_q.pop_front();
        checked_count++;
        if (got.cursor_pos !== want.cursor_pos)
            report("cursor_pos", want.cursor_pos, got.cursor_pos);
        if (got.cell_data !== want.cell_data)
            report("cell_data", want.cell_data, got.cell_data);
        if (got.scrolled !== want.scrolled)
            report("scrolled", want.scrolled, got.scrolled);
        if (got.out_of_range !== want.out_of_range)
            report("out_of_range", want.out_of_range, got.out_of_range);
    endfunction
endclass

module tb_text_console_cell_writer_top;

    localparam logic [CMD_W-1:0] CMD_SPARE_FIRST = 3'd5;
    localparam logic [CMD_W-1:0] CMD_SPARE_LAST  = 3'd7;
    localparam int PHASES         = 8;
    localparam int PHASE_ITEMS    = 200;
    localparam int CYCLE_LIMIT    = 20_000_000;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              cfg_wr_en;
    logic [ATTR_W-1:0] cfg_wr_data;
    bit                no_idle = 1'b0;
    int unsigned       sent_count = 0;
    int unsigned       attr_writes = 0;
    int unsigned       cycle_count = 0;

    tcw_cmd_if cmd_ch ();
    tcw_res_if res_ch ();

    console_scoreboard sb = new();

    console_cmd_t directed_list [$] = '{
        '{CMD_READ,   8'h00,    5'd0,          7'd0},
        '{CMD_READ,   8'h00,    5'(ROWS - 1),  7'(COLUMNS - 1)},
        '{CMD_READ,   8'h00,    5'd31,         7'd127},
        '{CMD_READ,   8'h00,    5'(ROWS),      7'd0},
        '{CMD_SET,    8'h00,    5'd0,          7'(COLUMNS)},
        '{CMD_PUT_AT, 8'hff,    5'(ROWS - 1),  7'(COLUMNS - 1)},
        '{CMD_PUT_AT, CH_NL,    5'd0,          7'd0},
        '{CMD_PUT_AT, 8'h41,    5'd31,         7'd5},
        '{CMD_PUT,    CH_BS,    5'd0,          7'd0},
        '{CMD_PUT,    8'h41,    5'd0,          7'd0},
        '{CMD_PUT,    CH_BS,    5'd0,          7'd0},
        '{CMD_READ,   8'h00,    5'd0,          7'd0},
        '{CMD_PUT,    CH_TAB,   5'd0,          7'd0},
        '{CMD_SET,    8'h00,    5'd0,          7'(COLUMNS - 2)},
        '{CMD_PUT,    CH_TAB,   5'd0,          7'd0},
        '{CMD_SET,    8'h00,    5'd0,          7'(COLUMNS - 1)},
        '{CMD_PUT,    8'h00,    5'd0,          7'd0},
        '{CMD_PUT,    CH_CR,    5'd0,          7'd0},
        '{CMD_SET,    8'h00,    5'(ROWS - 1),  7'(COLUMNS - 1)},
        '{CMD_PUT,    8'h80,    5'd0,          7'd0},
        '{CMD_READ,   8'h00,    5'(ROWS - 2),  7'(COLUMNS - 1)},
        '{CMD_SET,    8'h00,    5'(ROWS - 1),  7'd5},
        '{CMD_PUT,    CH_NL,    5'd0,          7'd0},
        '{CMD_SET,    8'h00,    5'(ROWS - 1),  7'(COLUMNS - 4)},
        '{CMD_PUT,    CH_TAB,   5'd0,          7'd0},
        '{CMD_SPARE_FIRST, 8'hff, 5'd31,       7'd127},
        '{CMD_SPARE_LAST,  8'h00, 5'd0,        7'd0},
        '{CMD_CLEAR,  8'h00,    5'd0,          7'd0},
        '{CMD_READ,   8'h00,    5'(ROWS - 1),  7'(COLUMNS - 1)}
    };

    text_console_cell_writer_top dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_cmd         (cmd_ch),
        .o_res         (res_ch)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles, %0d results outstanding",
                     $time, cycle_count, sb.pending());
            $display("end of test: mismatches");
            $finish;
        end
    end

    // result first: a result never belongs to the item taken at the same edge
    always @(posedge clk) begin
        if (rst_n) begin
            if (res_ch.valid && res_ch.ready)
                sb.check_result(t_res'{cursor_pos: res_ch.cursor_pos,
                                       cell_data: res_ch.cell_data,
                                       scrolled: res_ch.scrolled,
                                       out_of_range: res_ch.out_of_range});
            if (cmd_ch.valid && cmd_ch.ready)
                sb.note_command(console_cmd_t'{cmd_ch.cmd, cmd_ch.char_code,
                                               cmd_ch.row_index, cmd_ch.col_index});
        end
    end

    // result side back-pressure
    initial begin
        int unsigned stall;
        res_ch.ready = 1'b0;
        @(negedge clk);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, 10);
            if (stall != 0) begin
                res_ch.ready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            res_ch.ready = 1'b1;
            do @(posedge clk); while (!res_ch.valid);
            @(negedge clk);
        end
    end

    task automatic send_command(console_cmd_t c);
        int unsigned gap;
        gap = no_idle ? 0 : $urandom_range(0, 10);
        if (gap != 0) begin
            cmd_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        cmd_ch.cmd       = c.cmd;
        cmd_ch.char_code = c.ch;
        cmd_ch.row_index = c.row;
        cmd_ch.col_index = c.col;
        cmd_ch.valid     = 1'b1;
        do @(posedge clk); while (!cmd_ch.ready);
        sent_count++;
        @(negedge clk);
    endtask

    task automatic drain();
        cmd_ch.valid = 1'b0;
        while (sb.pending() != 0) @(negedge clk);
    endtask

    task automatic write_attribute(logic [ATTR_W-1:0] value);
        cfg_wr_en   = 1'b1;
        cfg_wr_data = value;
        @(negedge clk);
        cfg_wr_en = 1'b0;
        sb.set_attribute(value);
        attr_writes++;
    endtask

    function automatic console_cmd_t random_command();
        console_cmd_t c;
        int unsigned  pick;
        int unsigned  kind;
        pick = $urandom_range(0, 99);
        if (pick < 45)      c.cmd = CMD_PUT;
        else if (pick < 60) c.cmd = CMD_SET;
        else if (pick < 80) c.cmd = CMD_READ;
        else if (pick < 95) c.cmd = CMD_PUT_AT;
        else if (pick < 96) c.cmd = CMD_CLEAR;
        else                c.cmd = CMD_W'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST));

        kind = $urandom_range(0, 99);
        if (kind < 8)       c.ch = CH_NL;
        else if (kind < 11) c.ch = CH_CR;
        else if (kind < 16) c.ch = CH_BS;
        else if (kind < 21) c.ch = CH_TAB;
        else if (kind < 85) c.ch = CHAR_W'($urandom_range(CH_SPACE, 8'h7e));
        else                c.ch = CHAR_W'($urandom_range(0, 255));

        if ($urandom_range(0, 99) < 85) begin
            // set commands favor the bottom row, and all favor the right edge, to reach wraps and scrolls
            if (c.cmd == CMD_SET && $urandom_range(0, 99) < 40) c.row = ROW_W'(ROWS - 1);
            else c.row = ROW_W'($urandom_range(0, ROWS - 1));
            if ($urandom_range(0, 99) < 30) c.col = COL_W'($urandom_range(COLUMNS - 9, COLUMNS - 1));
            else c.col = COL_W'($urandom_range(0, COLUMNS - 1));
        end else begin
            c.row = ROW_W'($urandom_range(0, 31));
            c.col = COL_W'($urandom_range(0, 127));
        end
        return c;
    endfunction

    initial begin
        rst_n            = 1'b0;
        cfg_wr_en        = 1'b0;
        cfg_wr_data      = '0;
        cmd_ch.valid     = 1'b0;
        cmd_ch.cmd       = CMD_PUT;
        cmd_ch.char_code = '0;
        cmd_ch.row_index = '0;
        cmd_ch.col_index = '0;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;

        // reset attribute first, then explicit settings
        foreach (directed_list[i]) send_command(directed_list[i]);
        drain();

        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0:       write_attribute(8'h00);
                1:       write_attribute(8'hff);
                default: write_attribute(ATTR_W'($urandom_range(0, 255)));
            endcase
            no_idle = (phase == 2) || (phase == 5);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                send_command(random_command());
                if ($urandom_range(0, 63) == 0) drain();
            end
            drain();
        end

        no_idle = 1'b0;
        repeat (50) @(negedge clk);

        $display("%0d commands sent, %0d results checked, %0d attribute settings",
                 sent_count, sb.checked_count, attr_writes);
        $display("%0d scrolls and %0d out-of-range commands seen in %0d cycles",
                 sb.scroll_count, sb.bad_pos_count, cycle_count);
        if (sb.error_count == 0 && sb.pending() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
